[hw/rtl/vcr_pkg.sv]
// ----------------------------------------------------------------------------
// vcr_pkg
// Shared types and codes for the vsock connection responder.
// ----------------------------------------------------------------------------
package vcr_pkg;

    localparam logic [15:0] OP_REQUEST  = 16'd1;
    localparam logic [15:0] OP_RESPONSE = 16'd2;
    localparam logic [15:0] OP_RST      = 16'd3;
    localparam logic [15:0] OP_SHUTDOWN = 16'd4;
    localparam logic [15:0] OP_RW       = 16'd5;

    localparam logic [15:0] TYPE_STREAM    = 16'd1;
    localparam logic [15:0] TYPE_SEQPACKET = 16'd2;

    localparam logic [1:0]  FLAGS_NONE = 2'd0;
    localparam logic [1:0]  FLAGS_BOTH = 2'd3;

    localparam logic [31:0] BUF_ALLOC_RESET = 32'd1024;

    typedef enum logic [1:0] {
        CLS_REQUEST,
        CLS_RST,
        CLS_SHUTDOWN,
        CLS_RW
    } vcr_cls_t;

    // connection tuple as it arrives, unswapped
    typedef struct packed {
        logic [63:0] src_cid;
        logic [63:0] dst_cid;
        logic [31:0] from_port;
        logic [31:0] to_port;
    } vcr_key_t;

    typedef struct packed {
        vcr_key_t    key;
        logic [31:0] payload_len;
        logic [15:0] sock_type;
        vcr_cls_t    cls;
        logic        type_ok;
    } vcr_cmd_t;

    typedef struct packed {
        logic [63:0] src_cid;
        logic [63:0] dst_cid;
        logic [31:0] from_port;
        logic [31:0] to_port;
        logic [31:0] len;
        logic [15:0] sock_type;
        logic [15:0] op;
        logic [1:0]  flags;
        logic [31:0] alloc_bytes;
    } vcr_reply_t;

endpackage

[hw/rtl/vsock_connection_responder_core.sv]
// ----------------------------------------------------------------------------
// vsock_connection_responder_core
// Answers vsock packet headers and tracks open connections in a slot table.
//
//   channel   direction   handshake              payload
//   in        to core     in_valid / in_stall    src_cid .. op
//   out       from core   out_valid / out_stall  reply_src_cid .. reply_buf_alloc
//   cfg       to core     cfg_wr_en              cfg_wr_data (own_buffer_alloc)
//
// In the back end, each reply-producing header first registers the tuple
// compare against all slots (MATCH), then updates the table and loads the reply
// register (EXEC). A two-entry queue sits between decode and the back end.
// Reset empties the table and sets own_buffer_alloc to 1024.
// in_stall rises only when the queue is full; out_stall holds the reply
// register and, once the queue fills, backs up to the input.
// ----------------------------------------------------------------------------
module vsock_connection_responder_core
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] src_cid,
    input  logic [63:0] dst_cid,
    input  logic [31:0] from_port,
    input  logic [31:0] to_port,
    input  logic [31:0] payload_len,
    input  logic [15:0] sock_type,
    input  logic [15:0] op,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] reply_src_cid,
    output logic [63:0] reply_dst_cid,
    output logic [31:0] reply_src_port,
    output logic [31:0] reply_dst_port,
    output logic [31:0] reply_len,
    output logic [15:0] reply_type,
    output logic [15:0] reply_op,
    output logic [1:0]  reply_flags,
    output logic [31:0] reply_buf_alloc
);
    import vcr_pkg::*;

    logic [31:0] buf_alloc_reg;
    logic        push, pop, q_full, q_empty;
    vcr_cmd_t    push_data, pop_data;
    vcr_reply_t  reply;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_alloc_reg <= BUF_ALLOC_RESET;
        end
        else if (cfg_wr_en)
        begin
            buf_alloc_reg <= cfg_wr_data;
        end
    end

    vcr_front u_front
    (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .src_cid     (src_cid),
        .dst_cid     (dst_cid),
        .from_port   (from_port),
        .to_port     (to_port),
        .payload_len (payload_len),
        .sock_type   (sock_type),
        .op          (op),
        .push        (push),
        .push_data   (push_data),
        .q_full      (q_full)
    );

    vcr_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    vcr_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_data      (pop_data),
        .pop         (pop),
        .alloc_bytes (buf_alloc_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .reply       (reply)
    );

    assign reply_src_cid   = reply.src_cid;
    assign reply_dst_cid   = reply.dst_cid;
    assign reply_src_port  = reply.from_port;
    assign reply_dst_port  = reply.to_port;
    assign reply_len       = reply.len;
    assign reply_type      = reply.sock_type;
    assign reply_op        = reply.op;
    assign reply_flags     = reply.flags;
    assign reply_buf_alloc = reply.alloc_bytes;

endmodule

[hw/rtl/vcr_front.sv]
// ----------------------------------------------------------------------------
// vcr_front
// Takes packet headers, decodes the op and checks the socket type.
// Ops that get no reply are dropped here.
// ----------------------------------------------------------------------------
module vcr_front
(
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [63:0]       src_cid,
    input  logic [63:0]       dst_cid,
    input  logic [31:0]       from_port,
    input  logic [31:0]       to_port,
    input  logic [31:0]       payload_len,
    input  logic [15:0]       sock_type,
    input  logic [15:0]       op,
    output logic              push,
    output vcr_pkg::vcr_cmd_t push_data,
    input  logic              q_full
);
    import vcr_pkg::*;

    logic     keep;
    vcr_cls_t cls;

    always_comb
    begin
        keep = 1'b1;
        cls  = CLS_RST;
        unique case (op)
            OP_REQUEST:  cls = CLS_REQUEST;
            OP_RST:      cls = CLS_RST;
            OP_SHUTDOWN: cls = CLS_SHUTDOWN;
            OP_RW:       cls = CLS_RW;
            default:     keep = 1'b0;
        endcase
    end

    assign in_stall = q_full;
    assign push     = in_valid && !q_full && keep;

    always_comb
    begin
        push_data.key.src_cid   = src_cid;
        push_data.key.dst_cid   = dst_cid;
        push_data.key.from_port = from_port;
        push_data.key.to_port   = to_port;
        push_data.payload_len   = payload_len;
        push_data.sock_type     = sock_type;
        push_data.cls           = cls;
        push_data.type_ok       = (sock_type == TYPE_STREAM) || (sock_type == TYPE_SEQPACKET);
    end

endmodule

[hw/rtl/vcr_fifo.sv]
// ----------------------------------------------------------------------------
// vcr_fifo
// Two-entry command queue between the decode front and the table back end.
// ----------------------------------------------------------------------------
module vcr_fifo
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  vcr_pkg::vcr_cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output vcr_pkg::vcr_cmd_t pop_data,
    output logic              empty
);
    import vcr_pkg::*;

    vcr_cmd_t    mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg,  count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/vcr_back.sv]
// ----------------------------------------------------------------------------
// vcr_back
// Connection table and reply builder. The MATCH state registers the tuple match
// against every slot; the EXEC state then updates the table and loads the reply.
// ----------------------------------------------------------------------------
module vcr_back
#(
    parameter int TABLE_ENTRIES = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  vcr_pkg::vcr_cmd_t   q_data,
    output logic                pop,
    input  logic [31:0]         alloc_bytes,
    output logic                out_valid,
    input  logic                out_stall,
    output vcr_pkg::vcr_reply_t reply
);
    import vcr_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]               state_reg, state_next;
    vcr_cmd_t                 cur_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    vcr_key_t                 key_reg [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] hit_vec_reg, hit_vec_next;
    logic [TABLE_ENTRIES-1:0] free_vec_reg;
    logic [TABLE_ENTRIES-1:0] hit_oh, free_oh;
    logic                     hit_any, free_any;
    logic                     exec_fire;
    logic                     insert;
    logic                     out_valid_reg;
    vcr_reply_t               reply_reg, reply_next;

    always_comb
    begin
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            hit_vec_next[i] = valid_reg[i] && (key_reg[i] == cur_reg.key);
        end
    end

    // lowest set bit, one-hot
    assign hit_oh   = hit_vec_reg  & (~hit_vec_reg  + TABLE_ENTRIES'(1));
    assign free_oh  = free_vec_reg & (~free_vec_reg + TABLE_ENTRIES'(1));
    assign hit_any  = |hit_vec_reg;
    assign free_any = |free_vec_reg;

    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || !out_stall);
    assign pop       = !q_empty && ((state_reg == ST_IDLE) || exec_fire);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (pop) state_next = ST_MATCH;
            ST_MATCH: state_next = ST_EXEC;
            ST_EXEC:  if (exec_fire) state_next = pop ? ST_MATCH : ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        insert     = 1'b0;
        valid_next = valid_reg;

        reply_next.src_cid     = cur_reg.key.dst_cid;
        reply_next.dst_cid     = cur_reg.key.src_cid;
        reply_next.from_port   = cur_reg.key.to_port;
        reply_next.to_port     = cur_reg.key.from_port;
        reply_next.len         = 32'd0;
        reply_next.sock_type   = cur_reg.sock_type;
        reply_next.op          = OP_RST;
        reply_next.flags       = FLAGS_NONE;
        reply_next.alloc_bytes = 32'd0;

        unique case (cur_reg.cls)
            CLS_REQUEST:
            begin
                reply_next.alloc_bytes = alloc_bytes;
                if (cur_reg.type_ok && !hit_any && free_any)
                begin
                    reply_next.op = OP_RESPONSE;
                    insert        = 1'b1;
                    valid_next    = valid_reg | free_oh;
                end
            end
            CLS_RW:
            begin
                if (hit_any)
                begin
                    reply_next.op          = OP_RW;
                    reply_next.len         = cur_reg.payload_len;
                    reply_next.alloc_bytes = alloc_bytes;
                end
            end
            CLS_SHUTDOWN:
            begin
                if (hit_any)
                begin
                    reply_next.op    = OP_SHUTDOWN;
                    reply_next.flags = FLAGS_BOTH;
                    valid_next       = valid_reg & ~hit_oh;
                end
            end
            CLS_RST:
            begin
                valid_next = valid_reg & ~hit_oh;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_fire)
            begin
                valid_reg     <= valid_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_data;
        end
        if (state_reg == ST_MATCH)
        begin
            hit_vec_reg  <= hit_vec_next;
            free_vec_reg <= ~valid_reg;
        end
        if (exec_fire)
        begin
            reply_reg <= reply_next;
        end
        for (int i = 0; i < TABLE_ENTRIES; i++)
        begin
            if (exec_fire && insert && free_oh[i])
            begin
                key_reg[i] <= cur_reg.key;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign reply     = reply_reg;

endmodule
